### src/assert_macros.svh
// Assertion macros used by the RTL of the glyph code search block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property on every rising edge, idle while reset is asserted.
`define ASSERT_PROP(label, clk_sig, rstn_sig, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (prop)) \
        else $error("assertion failed in glyph code search");
// Check that a condition never holds on a rising edge.
`define ASSERT_NEVER(label, clk_sig, rstn_sig, cond) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) !(cond)) \
        else $error("forbidden condition in glyph code search");
`else
`define ASSERT_PROP(label, clk_sig, rstn_sig, prop)
`define ASSERT_NEVER(label, clk_sig, rstn_sig, cond)
`endif

`endif

### src/gcbs_pkg.sv
// Types and constants for the glyph code binary search unit.
`default_nettype none

package gcbs_pkg;

    localparam int CODE_W  = 21;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [INDEX_W-1:0] entry_index;
        logic [CODE_W-1:0]  entry_code;
        logic [CODE_W-1:0]  lookup_code;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] found_index;
        logic               hit;
    } out_item_t;

endpackage

`default_nettype wire

### src/glyph_code_binary_search_unit.sv
// Glyph code binary search unit: a lookup makes P table probes, at most floor(log2(n)) + 1
// for n entries in use (11 for 1024 entries); the key is compared with one code per
// cycle, fed by the single read port of the code table RAM. A load is written to the
// table when it is accepted. in_ready is low while a lookup runs; the finished result
// sits in an output register, so a load or the next lookup can transfer while that
// result still waits. There is no clearing pass after reset: the table must be loaded
// before lookups that probe it. entry_count above TABLE_DEPTH saturates at TABLE_DEPTH;
// loads with entry_index at or beyond TABLE_DEPTH are dropped.
`default_nettype none

`include "assert_macros.svh"

module glyph_code_binary_search_unit #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [gcbs_pkg::COUNT_W-1:0] cfg_wr_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire gcbs_pkg::in_item_t          in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output gcbs_pkg::out_item_t              out_data
);

    import gcbs_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (AW > INDEX_W) ? AW : INDEX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [CW-1:0]       lo_reg, lo_next;
    logic [CW-1:0]       hi_reg, hi_next;
    logic [AW-1:0]       mid_reg, mid_next;
    logic [CODE_W-1:0]   key_reg, key_next;
    out_item_t           res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_data_reg, out_data_next;

    logic [CW-1:0]       count_sat;
    logic [CW:0]         start_sum;
    logic [AW-1:0]       mid_start;
    logic [CW-1:0]       lo_step, hi_step;
    logic [CW:0]         step_sum;
    logic [XW-1:0]       mid_wide;
    logic [XW-1:0]       load_idx_wide;
    logic                load_ok;

    logic                ram_wr_en;
    logic                ram_rd_en;
    logic [AW-1:0]       ram_rd_addr;
    logic [CODE_W-1:0]   probe;

    // Clamp the entry count to the table depth
    always_comb
    begin
        if (32'(count_reg) > TABLE_DEPTH)
        begin
            count_sat = CW'(TABLE_DEPTH);
        end
        else
        begin
            count_sat = CW'(count_reg);
        end
    end

    // First probe sits at (n - 1) / 2
    assign start_sum = {1'b0, count_sat} - (CW+1)'(1);
    assign mid_start = start_sum[AW:1];

    // Narrow the bounds around the current probe
    always_comb
    begin
        if (key_reg < probe)
        begin
            lo_step = lo_reg;
            hi_step = CW'(mid_reg);
        end
        else
        begin
            lo_step = CW'(mid_reg) + CW'(1);
            hi_step = hi_reg;
        end
    end

    assign step_sum = {1'b0, lo_step} + {1'b0, hi_step} - (CW+1)'(1);
    assign mid_wide = XW'(mid_reg);

    // Drop loads that fall beyond the table
    assign load_ok       = (32'(in_data.entry_index) < TABLE_DEPTH);
    assign load_idx_wide = XW'(in_data.entry_index);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = mid_start;

        if (cfg_wr_en)
        begin
            count_next = cfg_wr_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.mode == MODE_LOAD)
                    begin
                        ram_wr_en = load_ok;
                    end
                    else
                    begin
                        key_next = in_data.lookup_code;
                        if (count_sat == '0)
                        begin
                            res_next.found_index = '0;
                            res_next.hit         = 1'b0;
                            state_next           = S_FINISH;
                        end
                        else
                        begin
                            lo_next     = '0;
                            hi_next     = count_sat;
                            mid_next    = mid_start;
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = mid_start;
                            state_next  = S_SEARCH;
                        end
                    end
                end
            end
            S_SEARCH:
            begin
                if (probe == key_reg)
                begin
                    res_next.found_index = mid_wide[INDEX_W-1:0];
                    res_next.hit         = 1'b1;
                    state_next           = S_FINISH;
                end
                else if (lo_step < hi_step)
                begin
                    lo_next     = lo_step;
                    hi_next     = hi_step;
                    mid_next    = step_sum[AW:1];
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = step_sum[AW:1];
                end
                else
                begin
                    res_next.found_index = '0;
                    res_next.hit         = 1'b0;
                    state_next           = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // Hand the result over once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
            key_reg       <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            mid_reg       <= mid_next;
            key_reg       <= key_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Code table
    gcbs_ram #(
        .WIDTH (CODE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_code_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (load_idx_wide[AW-1:0]),
        .wr_data (in_data.entry_code),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (probe)
    );

    `ASSERT_PROP(a_search_bounds_open, clk, rst_n,
        (state_reg == S_SEARCH) |-> (lo_reg < hi_reg) && (CW'(mid_reg) < hi_reg))
    `ASSERT_PROP(a_hit_within_count, clk, rst_n,
        (out_valid && out_data.hit) |-> (32'(out_data.found_index) < 32'(count_sat)))
    `ASSERT_NEVER(a_miss_nonzero_index, clk, rst_n,
        out_valid && !out_data.hit && (out_data.found_index != '0))
    `ASSERT_PROP(a_load_stays_idle, clk, rst_n,
        (in_valid && in_ready && (in_data.mode == MODE_LOAD)) |=> (state_reg == S_IDLE))
    `ASSERT_PROP(a_lookup_leaves_idle, clk, rst_n,
        (in_valid && in_ready && (in_data.mode == MODE_LOOKUP)) |=> (state_reg != S_IDLE))

endmodule

`default_nettype wire

### src/gcbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gcbs_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### bench/tb_glyph_code_binary_search_unit.sv
// Self-checking testbench for the glyph code binary search unit.
module tb_glyph_code_binary_search_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import gcbs_pkg::*;

    localparam int DEPTH         = 1024;
    localparam int CODE_MAX      = (1 << CODE_W) - 1;
    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD     = 400;
    localparam int RANDOM_ITEMS  = 1450;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [COUNT_W-1:0]  cfg_wr_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    in_item_t            in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    out_item_t           out_data;

    // Pending items for the driver, expected lookup results for the monitor
    in_item_t            pending_items[$];
    out_item_t           lookup_results_q[$];

    // Predicted block state: codes updated on each accepted load, count on each count write
    logic [CODE_W-1:0]   table_codes [DEPTH];
    logic [COUNT_W-1:0]  entry_count_p = '0;

    // Table contents as queued, used to pick lookup keys ahead of the driver
    logic [CODE_W-1:0]   plan_codes [DEPTH];

    int                  mismatches = 0;
    int                  gap_left = 0;
    int                  hold_left = 0;
    int                  hold_req = 0;
    int                  hold_seen = 0;
    bit                  calm = 1'b0;

    glyph_code_binary_search_unit #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Binary search over the entries in use; a miss falls back to index 0
    function automatic out_item_t predict_lookup(input logic [CODE_W-1:0] key);
        out_item_t res;
        int        lo;
        int        hi;
        int        mid;
        int        n;
        res = '0;
        n   = (entry_count_p > DEPTH) ? DEPTH : int'(entry_count_p);
        lo  = 0;
        hi  = n - 1;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (table_codes[mid] == key)
            begin
                res.found_index = INDEX_W'(mid);
                res.hit         = 1'b1;
                return res;
            end
            if (key < table_codes[mid])
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return res;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Driver: present queued items, hold them until the transfer, predict on transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (in_data.mode == MODE_LOAD)
                    table_codes[in_data.entry_index] = in_data.entry_code;
                else
                    lookup_results_q.push_back(predict_lookup(in_data.lookup_code));
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    in_data  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                    gap_left <= calm ? 0 : pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result transfer, then steer out_ready
    always @(posedge clk or negedge rst_n)
    begin : rx_side
        int   stall;
        out_item_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (lookup_results_q.size() == 0)
                    report_mismatch($sformatf("unexpected result index %0d hit %0b",
                                              out_data.found_index, out_data.hit));
                else
                begin
                    want = lookup_results_q.pop_front();
                    if (out_data.found_index !== want.found_index)
                        report_mismatch($sformatf("found_index %0d, predicted %0d",
                                                  out_data.found_index, want.found_index));
                    if (out_data.hit !== want.hit)
                        report_mismatch($sformatf("hit %0b, predicted %0b",
                                                  out_data.hit, want.hit));
                end
            end
            if (hold_req != hold_seen)
            begin
                // Long hold-off so the block fills up and stalls its input
                hold_seen <= hold_req;
                hold_left <= LONG_HOLD;
                out_ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (out_valid && out_ready)
            begin
                stall     = calm ? 0 : pick_gap();
                hold_left <= stall;
                out_ready <= (stall == 0);
            end
            else if (!calm && $urandom_range(0, 19) == 0)
            begin
                hold_left <= $urandom_range(0, 4);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Wait until every item is transferred and every result has arrived;
    // sample on the falling edge so the driver's updates have settled
    task automatic wait_quiet();
        @(negedge clk);
        while (pending_items.size() != 0 || in_valid || lookup_results_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_entry_count(input int unsigned value);
        wait_quiet();
        cfg_wr_en     <= 1'b1;
        cfg_wr_data   <= COUNT_W'(value);
        entry_count_p = COUNT_W'(value);
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
    endtask

    task automatic queue_load(input int idx, input int unsigned code);
        in_item_t it;
        it.mode          = MODE_LOAD;
        it.entry_index   = INDEX_W'(idx);
        it.entry_code    = CODE_W'(code);
        it.lookup_code   = CODE_W'($urandom());
        plan_codes[idx]  = it.entry_code;
        pending_items.push_back(it);
    endtask

    task automatic queue_lookup(input int unsigned key);
        in_item_t it;
        it.mode        = MODE_LOOKUP;
        it.entry_index = INDEX_W'($urandom());
        it.entry_code  = CODE_W'($urandom());
        it.lookup_code = CODE_W'(key);
        pending_items.push_back(it);
    endtask

    // Load entries 0..count-1 with non-decreasing codes
    task automatic queue_sorted_run(input int count);
        int unsigned cur;
        int          i;
        if ($urandom_range(0, 3) == 0)
            cur = $urandom_range(0, CODE_MAX);
        else
            cur = $urandom_range(0, CODE_MAX / 2);
        for (i = 0; i < count; i++)
        begin
            cur = cur + $urandom_range(0, (CODE_MAX - cur) / (count - i));
            queue_load(i, cur);
        end
    endtask

    // Mostly present codes and their neighbors, some arbitrary codes
    function automatic int unsigned pick_key(input int n);
        int unsigned k;
        int          sel;
        if (n > DEPTH)
            n = DEPTH;
        sel = $urandom_range(0, 9);
        if (n == 0 || sel >= 8)
            k = $urandom_range(0, CODE_MAX);
        else
        begin
            k = plan_codes[$urandom_range(0, n - 1)];
            if (sel == 6)
                k = k + 1;
            else if (sel == 7)
                k = k - 1;
        end
        return k & CODE_MAX;
    endfunction

    initial
    begin : stimulus
        int          issued;
        int          n;
        int          r;
        int          i;
        int          lookups;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table after reset: every lookup misses without probing
        queue_lookup(0);
        queue_lookup(CODE_MAX);
        queue_load(0, 1);
        queue_load(1, 5);
        queue_load(2, 1114111);
        queue_load(3, CODE_MAX);
        queue_load(DEPTH - 1, 21'h155555);

        // Four sorted entries: hits at both ends and inside, misses inside and below the first
        write_entry_count(4);
        queue_lookup(0);
        queue_lookup(1);
        queue_lookup(CODE_MAX);
        queue_lookup(1114111);
        queue_lookup(3);
        queue_lookup(CODE_MAX - 1);

        // Single entry in use
        write_entry_count(1);
        queue_lookup(1);
        queue_lookup(5);

        // Unsorted table: the rewritten entry is hit, its old code now misses
        write_entry_count(4);
        queue_load(1, CODE_MAX - 15);
        queue_lookup(CODE_MAX - 15);
        queue_lookup(5);

        // Fill the whole table so any count is safe from here on
        write_entry_count(DEPTH);
        queue_sorted_run(DEPTH);
        issued = DEPTH;
        for (i = 0; i < 40; i++)
            queue_lookup(pick_key(DEPTH));
        issued += 40;

        // Stall the receiver while full-depth lookups keep coming
        wait_quiet();
        hold_req++;
        for (i = 0; i < 30; i++)
            queue_lookup(pick_key(DEPTH));
        issued += 30;

        // Oversized counts saturate at the table depth
        write_entry_count(2047);
        for (i = 0; i < 20; i++)
            queue_lookup(pick_key(DEPTH));
        write_entry_count(DEPTH + 1);
        for (i = 0; i < 10; i++)
            queue_lookup(pick_key(DEPTH));
        issued += 30;

        // Random phases: new count, sorted reload for counts up to 200, lookups with some stray loads
        while (issued < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
                n = 0;
            else if (r < 12)
                n = $urandom_range(1, 2);
            else if (r < 82)
                n = $urandom_range(3, 48);
            else if (r < 90)
                n = $urandom_range(49, 200);
            else if (r < 95)
                n = DEPTH;
            else
                n = $urandom_range(DEPTH + 1, 2047);

            write_entry_count(n);
            calm = ($urandom_range(0, 99) < 25);
            if (n <= 200)
            begin
                queue_sorted_run(n);
                issued += n;
                if (n > 1 && $urandom_range(0, 99) < 15)
                begin
                    queue_load($urandom_range(0, n - 1), $urandom_range(0, CODE_MAX));
                    issued++;
                end
            end

            lookups = $urandom_range(8, 30);
            for (i = 0; i < lookups; i++)
            begin
                if ($urandom_range(0, 99) < 8)
                    queue_load($urandom_range(0, DEPTH - 1), $urandom_range(0, CODE_MAX));
                else
                    queue_lookup(pick_key(n));
            end
            issued += lookups;
        end

        wait_quiet();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Give up long after the slowest correct run would have ended
    initial
    begin
        #20000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
